// File: sv/keyframe_vector_sampler_core_assert.svh
// Assertion macros for the keyframe sampler.
`ifndef KEYFRAME_VECTOR_SAMPLER_CORE_ASSERT_SVH
`define KEYFRAME_VECTOR_SAMPLER_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define KVS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe sampler check failed");

// Next-cycle implication checked outside reset.
`define KVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe sampler check failed");

`endif

// File: sv/kvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared constants and types of the keyframe sampler.
// ----------------------------------------------------------------------------
package kvs_pkg;
  localparam int MaxKeysDefault = 64;
  localparam int WordW = 32;
  localparam int FracW = 16;
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] REG_INTERP_MODE = 2'd1;
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] t;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
    logic [WordW-1:0] w;
  } key_t;

  // Divider request and result.
  typedef struct packed {
    logic             start;
    logic [47:0]      num;
    logic [WordW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [47:0]      quo;
    logic [WordW-1:0] rem;
  } div_rsp_t;
endpackage

// File: sv/kvs_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_key_ram
// Keyframe table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kvs_key_ram import kvs_pkg::*; #(
  parameter int MAX_KEYS = MaxKeysDefault,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_t          wdata,
  input  logic [AW-1:0] raddr,
  output key_t          rdata
);
  key_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/kvs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_divider
// Restoring divider, 48-bit numerator by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module kvs_divider import kvs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [47:0] quo;
  logic [WordW-1:0] rem;
  logic [WordW-1:0] den;
  logic [32:0] shifted;
  logic [32:0] diff;

  // The partial remainder stays below the divisor, so 32 bits hold it.
  always_comb begin
    shifted = {rem, quo[47]};
    diff = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 6'd47;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[46:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
  assign rsp.rem = rem;
endmodule

// File: sv/keyframe_vector_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_core
// Keyframe table with linear or step sampling of a four-component value.
// ----------------------------------------------------------------------------
// Channel   Signals                         Direction
// in        in_valid/in_ready + fields      to block
// out       out_valid/out_ready + fields    from block
// cfg       cfg_valid/cfg_ready, index/data to block
//
// A query reads the table one entry at a time in the key scan. When looping
// with a nonzero last key time, a modulo division comes first; the modulo and
// the fraction share one serial divider.
// Reset clears control only; the table is undefined until loaded.
// The next item waits while a result is held in the output register.
module keyframe_vector_sampler_core import kvs_pkg::*; #(
  parameter int MAX_KEYS = MaxKeysDefault,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_time,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  input  logic [31:0] query_time,
  input  logic        loop_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic        past_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
`include "keyframe_vector_sampler_core_assert.svh"

  localparam logic [3:0] S_IDLE = 4'd0, S_LAST = 4'd1, S_LASTW = 4'd2,
    S_MOD = 4'd3, S_SCAN = 4'd4, S_SCANW = 4'd5, S_PAIR = 4'd6,
    S_PAIRW = 4'd7, S_DIV = 4'd8, S_BLEND = 4'd9, S_BLEND2 = 4'd10,
    S_OUT = 4'd11, S_HOLD = 4'd12;
  localparam logic [AW:0] MaxN = (AW+1)'(MAX_KEYS);

  logic [3:0]  state;
  logic [6:0]  key_count;
  logic        interp_mode;
  logic [AW:0] n_eff;
  logic [AW:0] k;
  logic [AW-1:0] idx;
  logic        found;
  logic [31:0] tq, t, lt, t0;
  logic        loop;
  key_t        k0;
  key_t        rdata;
  logic        we;
  logic [AW-1:0] raddr;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [16:0] f;
  logic signed [32:0] dv [4];
  logic signed [49:0] prod [4];
  logic [31:0] res [4];

  always_comb begin
    if (key_count == 7'd0) n_eff = (AW+1)'(1);
    else if ({25'd0, key_count} > 32'(MAX_KEYS)) n_eff = MaxN;
    else n_eff = (AW+1)'(key_count);
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign we = in_valid && in_ready && action == ACT_LOAD &&
              {26'd0, key_index} < 32'(MAX_KEYS);

  always_comb begin
    case (state)
      S_IDLE:  raddr = AW'(n_eff - (AW+1)'(1));
      S_OUT:   raddr = idx;
      S_PAIR:  raddr = idx + AW'(1);
      default: raddr = k[AW-1:0];
    endcase
  end

  kvs_key_ram #(.MAX_KEYS(MAX_KEYS)) u_ram (
    .clk(clk), .we(we), .waddr(AW'(key_index)),
    .wdata('{t: key_time, x: in_x, y: in_y, z: in_z, w: in_w}),
    .raddr(raddr), .rdata(rdata)
  );

  kvs_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    dreq = '0;
    if (state == S_LASTW && loop && rdata.t != 32'd0) begin
      dreq.start = 1'b1;
      dreq.num = {16'd0, tq};
      dreq.den = rdata.t;
    end else if (state == S_PAIRW && rdata.t - t0 != 32'd0) begin
      dreq.start = 1'b1;
      dreq.num = {t - t0, 16'd0};
      dreq.den = rdata.t - t0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 7'd1;
      interp_mode <= MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KEY_COUNT) key_count <= cfg_data[6:0];
      else if (cfg_index == REG_INTERP_MODE) interp_mode <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && action == ACT_QUERY) begin
            tq <= query_time;
            loop <= loop_enable;
            state <= S_LASTW;
          end
        end
        S_LASTW: begin
          lt <= rdata.t;
          k <= '0;
          found <= 1'b0;
          idx <= '0;
          if (loop && rdata.t != 32'd0) begin
            state <= S_MOD;
          end else begin
            t <= loop ? 32'd0 : tq;
            state <= S_SCAN;
          end
        end
        S_MOD: begin
          if (drsp.done) begin
            t <= drsp.rem;
            state <= S_SCAN;
          end
        end
        S_SCAN: state <= S_SCANW;
        S_SCANW: begin
          if (k == '0) k0 <= rdata;
          if (t > rdata.t) begin
            idx <= k[AW-1:0];
            t0 <= rdata.t;
            found <= 1'b1;
            if (k + (AW+1)'(1) == n_eff) state <= S_OUT;
            else begin
              k <= k + (AW+1)'(1);
              state <= S_SCAN;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_PAIR: state <= S_PAIRW;
        S_PAIRW: begin
          k0 <= rdata;
          if (rdata.t - t0 == 32'd0) begin
            f <= 17'd65536;
            state <= S_BLEND;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            f <= (drsp.quo > 48'd65536) ? 17'd65536 : drsp.quo[16:0];
            state <= S_BLEND;
          end
        end
        S_BLEND: state <= S_BLEND2;
        S_BLEND2: begin
          out_x <= res[0];
          out_y <= res[1];
          out_z <= res[2];
          out_w <= res[3];
          past_end <= tq > lt;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_OUT: begin
          // Decide between holding a key and blending toward the next one.
          if (!found || interp_mode == MODE_STEP ||
              {1'b0, idx} == n_eff - (AW+1)'(1)) begin
            if (found) begin
              k <= {1'b0, idx};
              state <= S_LAST;
            end else begin
              out_x <= k0.x;
              out_y <= k0.y;
              out_z <= k0.z;
              out_w <= k0.w;
              past_end <= tq > lt;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            // Key i is read here and key i+1 in the pair read.
            state <= S_PAIR;
          end
        end
        S_LAST: state <= S_HOLD;
        S_HOLD: begin
          // Read of the held key finishes here.
          out_x <= rdata.x;
          out_y <= rdata.y;
          out_z <= rdata.z;
          out_w <= rdata.w;
          past_end <= tq > lt;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Key i values kept for the blend.
  key_t ki;
  always_ff @(posedge clk) begin
    if (state == S_PAIR) ki <= rdata;
  end

  // ki holds key i, read while in S_OUT; k0 holds key i+1 after the pair read.
  logic [31:0] va [4];
  logic [31:0] vb [4];
  assign va = '{ki.x, ki.y, ki.z, ki.w};
  assign vb = '{k0.x, k0.y, k0.z, k0.w};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (state == S_BLEND) begin
        prod[i] <= $signed({{18{vb[i][31]}}, vb[i]} - {{18{va[i][31]}}, va[i]}) *
                   $signed({33'd0, f});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dv[i] = 33'(prod[i] >>> FracW);
      res[i] = va[i] + dv[i][31:0];
    end
  end

  `KVS_ASSERT_IMPL(a_ready_idle, in_ready, state == S_IDLE && !out_valid)
  `KVS_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid)
  `KVS_ASSERT_IMPL(a_no_load_busy, we, state == S_IDLE)
endmodule

// File: sim/keyframe_vector_sampler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_core_tb
// Loads keyframe tables and samples them. A small directed table covers
// reset state, extremes, looping, step mode and the saturation of the key
// count. Random phases follow, each with new register settings. Every sampled
// result is checked against a behavioral model of the key scan and blend.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler_core_tb;
  import kvs_pkg::*;

  localparam int NKEYS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic        act;
    logic [5:0]  slot;
    logic [31:0] ktime;
    logic [31:0] vx, vy, vz, vw;
    logic [31:0] qtime;
    logic        wrap;
  } item_t;

  typedef struct {
    logic [31:0] x, y, z, w;
    logic        pe;
  } sample_t;

  typedef struct {
    item_t   it;
    bit      known;
    sample_t res;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, action, loop_enable;
  logic [5:0] key_index;
  logic [31:0] key_time, query_time;
  logic signed [31:0] in_x, in_y, in_z, in_w;
  logic out_valid, out_ready, past_end;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  // Model state.
  logic [31:0] tbl_t [NKEYS];
  logic [31:0] tbl_v [NKEYS][4];
  logic [6:0]  mdl_count;
  logic        mdl_mode;

  sample_t samples_due[$];
  row_t    directed[$];
  int      mismatches, samples_seen, items_sent, watchdog;
  bit      rx_stall_on;

  keyframe_vector_sampler_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h (sample %0d)", what, got, want, samples_seen);
  endtask

  function automatic logic [31:0] blend_comp(input logic [31:0] a, input logic [31:0] b,
                                             input logic [16:0] f);
    longint sa, d, p, q;
    sa = longint'($signed(a));
    d = longint'($signed(b)) - sa;
    p = d * longint'(f);
    // Arithmetic shift floors toward minus infinity.
    q = p >>> 16;
    return 32'(sa + q);
  endfunction

  function automatic sample_t sample_at(input logic [31:0] tq, input logic wrap);
    sample_t r;
    int n, last, idx, sel;
    bit found;
    logic [31:0] lt, t, diff;
    logic [63:0] f;
    n = (mdl_count == 0) ? 1 : (mdl_count > NKEYS ? NKEYS : int'(mdl_count));
    last = n - 1;
    lt = tbl_t[last];
    t = tq;
    if (wrap) t = (lt != 0) ? tq % lt : 32'd0;
    found = 0;
    idx = 0;
    for (int k = 0; k < n; k++) begin
      if (t > tbl_t[k]) begin
        idx = k;
        found = 1;
      end else break;
    end
    if (!found || mdl_mode == MODE_STEP || idx == last) begin
      sel = found ? idx : 0;
      r.x = tbl_v[sel][0]; r.y = tbl_v[sel][1]; r.z = tbl_v[sel][2]; r.w = tbl_v[sel][3];
    end else begin
      diff = tbl_t[idx+1] - tbl_t[idx];
      if (diff == 0) f = 65536;
      else begin
        f = {32'd0, t - tbl_t[idx]} << 16;
        f = f / diff;
        if (f > 65536) f = 65536;
      end
      r.x = blend_comp(tbl_v[idx][0], tbl_v[idx+1][0], f[16:0]);
      r.y = blend_comp(tbl_v[idx][1], tbl_v[idx+1][1], f[16:0]);
      r.z = blend_comp(tbl_v[idx][2], tbl_v[idx+1][2], f[16:0]);
      r.w = blend_comp(tbl_v[idx][3], tbl_v[idx+1][3], f[16:0]);
    end
    r.pe = tq > lt;
    return r;
  endfunction

  function automatic item_t load_item(input int s, input logic [31:0] kt, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic [31:0] w);
    item_t it;
    it = '{ACT_LOAD, 6'(s), kt, x, y, z, w, $urandom, 1'($urandom)};
    return it;
  endfunction

  function automatic item_t query_item(input logic [31:0] tq, input logic wrap);
    item_t it;
    it = '{ACT_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, tq, wrap};
    return it;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_COUNT) mdl_count = data[6:0];
    else if (idx == REG_INTERP_MODE) mdl_mode = data[0];
    @(posedge clk);
  endtask

  // Waits for every sample and then lets a load in flight settle.
  task automatic drain();
    while (samples_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Drives one item and updates the model at acceptance.
  task automatic send(input item_t it, input bit known, input sample_t res);
    sample_t exp_s;
    action <= it.act; key_index <= it.slot; key_time <= it.ktime;
    in_x <= it.vx; in_y <= it.vy; in_z <= it.vz; in_w <= it.vw;
    query_time <= it.qtime; loop_enable <= it.wrap;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.act == ACT_LOAD) begin
      tbl_t[it.slot] = it.ktime;
      tbl_v[it.slot] = '{it.vx, it.vy, it.vz, it.vw};
    end else begin
      exp_s = sample_at(it.qtime, it.wrap);
      if (known) begin
        if (exp_s.x !== res.x) report("directed x", res.x, exp_s.x);
        if (exp_s.y !== res.y) report("directed y", res.y, exp_s.y);
        if (exp_s.z !== res.z) report("directed z", res.z, exp_s.z);
        if (exp_s.w !== res.w) report("directed w", res.w, exp_s.w);
        if (exp_s.pe !== res.pe) report("directed past_end", res.pe, exp_s.pe);
      end
      samples_due.push_back(exp_s);
    end
  endtask

  // Burst sender: random bursts, random gaps between them.
  int burst_left;
  task automatic send_paced(input item_t it);
    sample_t none;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send(it, 0, none);
  endtask

  // Receiver stall pattern: alternating stall and free stretches.
  initial begin
    out_ready = 1'b0;
    rx_stall_on = 0;
    @(negedge rst);
    forever begin
      int len;
      len = rx_stall_on ? $urandom_range(1, 30) : $urandom_range(1, 60);
      repeat (len) begin
        @(posedge clk);
        out_ready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
      rx_stall_on = !rx_stall_on;
    end
  end

  always @(posedge clk) begin
    sample_t e;
    if (!rst && out_valid && out_ready) begin
      samples_seen++;
      if (samples_due.size() == 0) begin
        mismatches++;
        $display("sample with nothing expected");
      end else begin
        e = samples_due.pop_front();
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_z !== e.z) report("out_z", out_z, e.z);
        if (out_w !== e.w) report("out_w", out_w, e.w);
        if (past_end !== e.pe) report("past_end", past_end, e.pe);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("keyframe_vector_sampler_core_tb NOT OK");
      $finish;
    end
  end

  // Loads n keys with ascending times, sometimes with equal neighbors.
  task automatic load_table(input int n, input bit paced);
    logic [31:0] tm;
    int step_max;
    sample_t none;
    step_max = (n > 1) ? 32'hFFFF_FFFF / n : 32'hFFFF_FFFF;
    tm = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, step_max);
    for (int k = 0; k < n; k++) begin
      item_t it;
      it = load_item(k, tm, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        it.vx = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        it.vy = 32'($signed(16'($urandom)));
      end
      if (paced) send_paced(it); else send(it, 0, none);
      if ($urandom_range(0, 7) != 0) tm = tm + $urandom_range(1, step_max);
    end
  endtask

  function automatic logic [31:0] pick_time(input int n);
    logic [31:0] lt;
    int k;
    lt = tbl_t[n-1];
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: return tbl_t[k];
      1: return tbl_t[k] + 1;
      2: return lt + $urandom_range(0, 5);
      3: return 32'hFFFF_FFFF;
      default: return (lt == 0) ? $urandom : $urandom_range(0, lt);
    endcase
  endfunction

  initial begin
    sample_t s0, smax, none;
    int n;
    rst = 1'b1;
    in_valid = 1'b0; action = ACT_LOAD; key_index = '0; key_time = '0;
    in_x = '0; in_y = '0; in_z = '0; in_w = '0; query_time = '0; loop_enable = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_KEY_COUNT; cfg_data = '0;
    mismatches = 0; samples_seen = 0; items_sent = 0; watchdog = 0; burst_left = 0;
    mdl_count = 7'd1; mdl_mode = MODE_LINEAR;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one key at extreme values, then a two-key blend across full range.
    s0 = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0};
    smax = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1};
    directed.push_back('{load_item(0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF),
                         0, none});
    directed.push_back('{query_item(32'd0, 1'b0), 1, s0});
    directed.push_back('{query_item(32'hFFFF_FFFF, 1'b0), 1, smax});
    directed.push_back('{query_item(32'hFFFF_FFFF, 1'b1), 1, smax});
    directed.push_back('{load_item(63, 32'hFFFF_FFFF, 1, 2, 3, 4), 0, none});
    foreach (directed[i]) send(directed[i].it, directed[i].known, directed[i].res);
    in_valid <= 1'b0;
    drain();
    directed.delete();

    cfg_write(REG_KEY_COUNT, 32'd2);
    directed.push_back('{load_item(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 0), 0, none});
    directed.push_back('{load_item(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h8000_0000, 32'hFFFF_0000), 0, none});
    directed.push_back('{query_item(32'h0000_0000, 1'b0), 0, none});  // below first key
    directed.push_back('{query_item(32'h0001_0000, 1'b0), 0, none});
    directed.push_back('{query_item(32'h0001_0001, 1'b0), 0, none});
    directed.push_back('{query_item(32'h0002_0000, 1'b0), 0, none});
    directed.push_back('{query_item(32'h0003_0000, 1'b0), 0, none});
    directed.push_back('{query_item(32'h0005_8000, 1'b1), 0, none});  // wraps
    directed.push_back('{query_item(32'hFFFF_FFFF, 1'b0), 0, none});
    foreach (directed[i]) send(directed[i].it, directed[i].known, directed[i].res);
    in_valid <= 1'b0;
    drain();
    directed.delete();

    // Step mode, a zero key count and an oversized one.
    cfg_write(REG_INTERP_MODE, {31'd0, MODE_STEP});
    send(query_item(32'h0002_0000, 1'b0), 0, none);
    in_valid <= 1'b0;
    drain();
    cfg_write(REG_INTERP_MODE, {31'd0, MODE_LINEAR});
    cfg_write(REG_KEY_COUNT, 32'd0);
    send(query_item(32'h0002_0000, 1'b0), 0, none);
    in_valid <= 1'b0;
    drain();
    load_table(NKEYS, 0);
    in_valid <= 1'b0;
    cfg_write(REG_KEY_COUNT, 32'h7F);
    send(query_item(32'hFFFF_FFFF, 1'b0), 0, none);
    send(query_item(tbl_t[40] + 1, 1'b0), 0, none);
    send(query_item(32'h1234_5678, 1'b1), 0, none);
    in_valid <= 1'b0;
    drain();

    // Random phases: new settings, a fresh table, then a run of queries.
    while (items_sent < 1600) begin
      int nq;
      n = ($urandom_range(0, 7) == 0) ? NKEYS : $urandom_range(1, 12);
      cfg_write(REG_KEY_COUNT, ($urandom_range(0, 15) == 0) ? 32'd0 : 32'(n));
      if (mdl_count == 0) n = 1;
      cfg_write(REG_INTERP_MODE, {31'd0, 1'($urandom_range(0, 3) == 0)});
      load_table(n, 1);
      nq = $urandom_range(5, 40);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Load random data into a slot past n, or send a query when no such slot is drawn.
          int sl;
          sl = $urandom_range(n, NKEYS - 1 + (n == NKEYS ? 0 : 0));
          if (sl < NKEYS && sl >= n)
            send_paced(load_item(sl, $urandom, $urandom, $urandom, $urandom, $urandom));
          else send_paced(query_item(pick_time(n), 1'($urandom)));
        end else send_paced(query_item(pick_time(n), 1'($urandom)));
      end
      in_valid <= 1'b0;
      drain();
    end
    in_valid <= 1'b0;

    drain();
    repeat (300) @(posedge clk);
    $display("sent %0d items (loads and queries), checked %0d samples", items_sent,
             samples_seen);
    $display("covered linear and step modes, looping, past-end and key counts 0 to 127");
    if (mismatches == 0 && samples_due.size() == 0)
      $display("keyframe_vector_sampler_core_tb OK");
    else
      $display("keyframe_vector_sampler_core_tb NOT OK");
    $finish;
  end
endmodule

// File: keyframe_vector_sampler_core.f
+incdir+sv
sv/kvs_pkg.sv
sv/kvs_key_ram.sv
sv/kvs_divider.sv
sv/keyframe_vector_sampler_core.sv
sim/keyframe_vector_sampler_core_tb.sv
